// ===== rtl/http_request_byte_tagger_assert.svh =====
// ----------------------------------------------------------------------------
// http request byte tagger assertion macros
// concurrent checks clocked on clk and disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_BYTE_TAGGER_ASSERT_SVH
`define HTTP_REQUEST_BYTE_TAGGER_ASSERT_SVH

// same-cycle implication
`define HBT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("http byte tagger check failed");

// next-cycle implication
`define HBT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("http byte tagger check failed");

`endif

// ===== rtl/httpbt_pkg.sv =====
// ----------------------------------------------------------------------------
// httpbt_pkg
// types, byte codes and tag codes shared by the http byte tagger
// ----------------------------------------------------------------------------
package httpbt_pkg;

  typedef enum logic [2:0] {
    PH_METHOD = 3'd0,
    PH_URL    = 3'd1,
    PH_SEARCH = 3'd2,
    PH_MAJOR  = 3'd3,
    PH_MINOR  = 3'd4,
    PH_TAIL   = 3'd5,
    PH_HEADER = 3'd6,
    PH_BODY   = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    TG_METHOD = 3'd0,
    TG_SKIP   = 3'd1,
    TG_URL    = 3'd2,
    TG_VER    = 3'd3,
    TG_NAME   = 3'd4,
    TG_VALUE  = 3'd5,
    TG_EOL    = 3'd6,
    TG_BODY   = 3'd7
  } tag_t;

  localparam logic [1:0] MTH_GET   = 2'd0;
  localparam logic [1:0] MTH_POST  = 2'd1;
  localparam logic [1:0] MTH_OTHER = 2'd2;

  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [2:0] PROTO_LEN = 3'd5;

  // prefix_match values in the header phase
  localparam logic [2:0] PM_AFTER_COLON = 3'd1;
  localparam logic [2:0] PM_IN_VALUE    = 3'd2;

  // one result word
  typedef struct packed {
    logic [7:0]  byte_out;
    tag_t        tag;
    logic [1:0]  method;
    logic [15:0] major_version;
    logic [15:0] minor_version;
    logic        entry_done;
    logic        last_out;
  } result_t;

  // letters of "HTTP/"
  function automatic logic [7:0] proto_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = CH_H;
      3'd1:    c = 8'h54;
      3'd2:    c = 8'h54;
      3'd3:    c = CH_P;
      3'd4:    c = 8'h2f;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/httpbt_parse.sv =====
// ----------------------------------------------------------------------------
// httpbt_parse
// parser state and the per-byte tag and version update
// ----------------------------------------------------------------------------
module httpbt_parse #(
  parameter int VERSION_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic [7:0]          byte_in,
  input  logic                last,
  output httpbt_pkg::result_t result
);
  import httpbt_pkg::*;

  localparam int WW = VERSION_WIDTH + 4;

  phase_t                     phase, phase_next;
  logic [1:0]                 method_code, method_code_next;
  logic [VERSION_WIDTH-1:0]   major_acc, major_acc_next;
  logic [VERSION_WIDTH-1:0]   minor_acc, minor_acc_next;
  logic [2:0]                 prefix_match, prefix_match_next;
  logic                       colon_seen, colon_seen_next;
  logic                       skip_next, skip_next_next;
  logic                       line_empty, line_empty_next;

  tag_t                       tag;
  logic                       done;
  logic                       cr_end;
  logic                       is_digit;
  logic                       proto_hit;
  logic [3:0]                 digit;
  logic [WW-1:0]              major_wide, minor_wide;
  logic [VERSION_WIDTH-1:0]   major_sat, minor_sat;

  assign cr_end = (phase <= PH_TAIL) && (byte_in == CH_CR) &&
                  !((phase == PH_METHOD) && (prefix_match == 3'd0));
  assign is_digit  = byte_in inside {[CH_ZERO:CH_NINE]};
  assign proto_hit = (prefix_match < PROTO_LEN) && (byte_in == proto_char(prefix_match));
  assign digit     = 4'(byte_in - CH_ZERO);

  // acc * 10 + d as shift and add, then clamp
  assign major_wide = (WW'(major_acc) << 3) + (WW'(major_acc) << 1) + WW'(digit);
  assign minor_wide = (WW'(minor_acc) << 3) + (WW'(minor_acc) << 1) + WW'(digit);
  assign major_sat  = (major_wide[WW-1:VERSION_WIDTH] != 4'd0) ? {VERSION_WIDTH{1'b1}}
                                                               : major_wide[VERSION_WIDTH-1:0];
  assign minor_sat  = (minor_wide[WW-1:VERSION_WIDTH] != 4'd0) ? {VERSION_WIDTH{1'b1}}
                                                               : minor_wide[VERSION_WIDTH-1:0];

  // next phase
  always_comb begin
    phase_next = phase;
    if (cr_end) begin
      phase_next = PH_HEADER;
    end else begin
      case (phase)
        PH_METHOD: if (prefix_match != 3'd0 && byte_in == CH_SPACE) phase_next = PH_URL;
        PH_URL:    if (byte_in == CH_SPACE) phase_next = PH_SEARCH;
        PH_SEARCH: if (proto_hit && prefix_match == PROTO_LEN - 3'd1) phase_next = PH_MAJOR;
        PH_MAJOR:  if (byte_in == CH_DOT) phase_next = PH_MINOR;
        PH_MINOR:  if (!is_digit) phase_next = PH_TAIL;
        PH_HEADER: if (skip_next && line_empty) phase_next = PH_BODY;
        default:   phase_next = phase;
      endcase
    end
  end

  // tag and the rest of the state
  always_comb begin
    tag               = TG_SKIP;
    done              = 1'b0;
    method_code_next  = method_code;
    major_acc_next    = major_acc;
    minor_acc_next    = minor_acc;
    prefix_match_next = prefix_match;
    colon_seen_next   = colon_seen;
    skip_next_next    = skip_next;
    line_empty_next   = line_empty;
    if (cr_end) begin
      tag             = TG_EOL;
      skip_next_next  = 1'b1;
      line_empty_next = 1'b0;
    end else begin
      case (phase)
        PH_METHOD: begin
          if (prefix_match == 3'd0) begin
            method_code_next  = (byte_in == CH_G) ? MTH_GET :
                                (byte_in == CH_P) ? MTH_POST : MTH_OTHER;
            prefix_match_next = 3'd1;
            tag               = TG_METHOD;
          end else if (byte_in == CH_SPACE) begin
            prefix_match_next = 3'd0;
          end else begin
            tag = TG_METHOD;
          end
        end
        PH_URL: begin
          if (byte_in == CH_SPACE) begin
            prefix_match_next = 3'd0;
          end else begin
            tag = TG_URL;
          end
        end
        PH_SEARCH: begin
          tag = TG_VER;
          if (proto_hit) begin
            prefix_match_next = (prefix_match == PROTO_LEN - 3'd1) ? 3'd0
                                                                   : prefix_match + 3'd1;
          end else begin
            prefix_match_next = (byte_in == CH_H) ? 3'd1 : 3'd0;
          end
        end
        PH_MAJOR: begin
          tag = TG_VER;
          if (byte_in != CH_DOT && is_digit) major_acc_next = major_sat;
        end
        PH_MINOR: begin
          if (is_digit) begin
            tag            = TG_VER;
            minor_acc_next = minor_sat;
          end
        end
        PH_TAIL: tag = TG_SKIP;
        PH_HEADER: begin
          if (skip_next) begin
            tag            = TG_EOL;
            skip_next_next = 1'b0;
            if (!line_empty) begin
              line_empty_next   = 1'b1;
              colon_seen_next   = 1'b0;
              prefix_match_next = 3'd0;
            end
          end else if (byte_in == CH_CR) begin
            tag            = TG_EOL;
            done           = colon_seen;
            skip_next_next = 1'b1;
          end else begin
            line_empty_next = 1'b0;
            if (!colon_seen) begin
              if (byte_in == CH_COLON) begin
                colon_seen_next   = 1'b1;
                prefix_match_next = PM_AFTER_COLON;
              end else begin
                tag = TG_NAME;
              end
            end else if (prefix_match == PM_AFTER_COLON) begin
              prefix_match_next = PM_IN_VALUE;
            end else begin
              tag = TG_VALUE;
            end
          end
        end
        default: tag = TG_BODY;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (adv && last)) begin
      phase        <= PH_METHOD;
      method_code  <= MTH_GET;
      major_acc    <= '0;
      minor_acc    <= '0;
      prefix_match <= 3'd0;
      colon_seen   <= 1'b0;
      skip_next    <= 1'b0;
      line_empty   <= 1'b0;
    end else if (adv) begin
      phase        <= phase_next;
      method_code  <= method_code_next;
      major_acc    <= major_acc_next;
      minor_acc    <= minor_acc_next;
      prefix_match <= prefix_match_next;
      colon_seen   <= colon_seen_next;
      skip_next    <= skip_next_next;
      line_empty   <= line_empty_next;
    end
  end

  always_comb begin
    result.byte_out      = byte_in;
    result.tag           = tag;
    result.method        = method_code_next;
    result.major_version = 16'(major_acc_next);
    result.minor_version = 16'(minor_acc_next);
    result.entry_done    = done;
    result.last_out      = last;
  end

  `include "http_request_byte_tagger_assert.svh"

  `HBT_ASSERT_SAME(a_done_on_cr, adv && done, tag == TG_EOL && byte_in == CH_CR && phase == PH_HEADER)
  `HBT_ASSERT_NEXT(a_last_resets, adv && last, phase == PH_METHOD && prefix_match == 3'd0)
  `HBT_ASSERT_NEXT(a_body_sticks, phase == PH_BODY && !(adv && last), phase == PH_BODY)
  `HBT_ASSERT_SAME(a_method_tag, adv && tag == TG_METHOD, phase == PH_METHOD)

endmodule

// ===== rtl/httpbt_out_reg.sv =====
// ----------------------------------------------------------------------------
// httpbt_out_reg
// result register on the master side of the tagger
// ----------------------------------------------------------------------------
module httpbt_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  httpbt_pkg::result_t result,
  output logic                room,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [47:0]         m_tdata,
  output logic [2:0]          m_tuser,
  output logic                m_tlast
);
  import httpbt_pkg::*;

  result_t held;

  assign room = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (room) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (room && load) begin
      held <= result;
    end
  end

  assign m_tdata = {5'd0, held.entry_done, held.minor_version, held.major_version,
                    held.method, held.byte_out};
  assign m_tuser = held.tag;
  assign m_tlast = held.last_out;

endmodule

// ===== rtl/http_request_byte_tagger.sv =====
// ----------------------------------------------------------------------------
// http_request_byte_tagger
// tags each byte of an http request with the part of the request it is in
// ----------------------------------------------------------------------------
// Feed the request text one byte per word on the slave stream, with tlast on
// the final byte; the parser returns to its start state after that byte. Each
// byte comes back on the master stream as one word carrying the byte, its tag
// (method, separator, url, version, field name, field value, line end, body),
// the method, the major and minor version reached so far, and a strobe on the
// CR that closes a header line holding a colon. Throughput is one byte per
// clock while m_tready allows it: an input register feeds the parser logic,
// whose result lands in the output register in the same cycle the parser
// state advances, and the word shows on the master side from that register.
// Backpressure from m_tready passes back combinationally to s_tready through
// the two stages. Versions saturate at 2**VERSION_WIDTH-1, shown as 16 bits.
module http_request_byte_tagger #(
  parameter int VERSION_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_in
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [7:0] byte_out, [9:8] method, [25:10] major_version,
                                 // [41:26] minor_version, [42] entry_done, rest zero
  output logic [2:0]  m_tuser,   // [2:0] tag
  output logic        m_tlast    // last_out
);
  import httpbt_pkg::*;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // handoff from the input register into the parser and result register
  logic       out_room;
  logic       adv;
  result_t    result;

  assign adv      = in_valid && out_room;
  assign s_tready = !in_valid || out_room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // payload holds while the word waits
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // parser state advances exactly when a byte moves into the result register
  httpbt_parse #(
    .VERSION_WIDTH(VERSION_WIDTH)
  ) u_parse (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .byte_in(in_byte),
    .last   (in_last),
    .result (result)
  );

  httpbt_out_reg u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (adv),
    .result  (result),
    .room    (out_room),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

endmodule
